### design/lobm_pkg.sv
// ----------------------------------------------------------------------------
// Limit order book matcher package
// Shared codes, item layouts and the bit-scan result type.
// ----------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

  localparam int PRICE_W    = 32;
  localparam int QTY_W      = 32;
  localparam int ID_W       = 32;
  localparam int STATUS_W   = 3;
  localparam int MAP_WORD_W = 32;
  localparam int MAP_BIT_W  = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [MAP_BIT_W-1:0] BIT_TOP    = 5'd31;
  localparam logic [MAP_BIT_W-1:0] BIT_BOTTOM = 5'd0;

  // operation codes
  localparam logic OP_NEW    = 1'b0;
  localparam logic OP_CANCEL = 1'b1;

  // side codes
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // order kinds
  localparam logic KIND_LIMIT  = 1'b0;
  localparam logic KIND_MARKET = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_RESTED    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FILLED    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DROPPED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_OUTSIDE   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_CANCELLED = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND  = 3'd6;

  // configuration register byte addresses
  localparam logic [CFG_ADDR_W-1:0] ADDR_FIXED_WINDOW = 3'd0;

  // one resting order in a level queue
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [QTY_W-1:0] qty;
  } qent_t;

  // one order tracker entry
  typedef struct packed {
    logic               active;
    logic               side;
    logic [PRICE_W-1:0] price;
  } trk_t;

  // bit-scan result
  typedef struct packed {
    logic                 found;
    logic [MAP_BIT_W-1:0] pos;
  } scan_res_t;

endpackage

`default_nettype wire

### design/limit_order_book_matcher_core.sv
// ----------------------------------------------------------------------------
// Limit order book matcher core
// Price-time priority book with a windowed price ladder per side.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one item (new order or cancel). The
// core raises busy and walks the book with one sequencer over four memories,
// each with one write and one registered read port (level bitmap, level fill
// counts, level queues, order tracker). A new order checks the opposite best
// level, trades against its resting orders oldest first, removes each order
// it fills out and shifts the queue up, and rests any limit remainder. Emptying
// a level drops it from the bitmap and scans bitmap words for the next best
// price. A cancel with a trackable id looks it up in the tracker, searches the
// level queue for it and shifts the queue up; an untrackable id is reported
// not found. The result appears for exactly one cycle with done_o high, in the
// same cycle that busy falls, and cannot be held off. After reset the core
// clears the tracker and bitmap with busy high. Configuration writes are taken
// at any time; change the window mode only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module limit_order_book_matcher_core
  import lobm_pkg::*;
#(
  parameter int WINDOW_LEVELS  = 1024,
  parameter int TRACKED_ORDERS = 4096,
  parameter int LEVEL_DEPTH    = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  op_i,
  input  wire logic [ID_W-1:0]       order_id_i,
  input  wire logic                  side_i,
  input  wire logic                  order_kind_i,
  input  wire logic [PRICE_W-1:0]    price_i,
  input  wire logic [QTY_W-1:0]      quantity_i,
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [QTY_W-1:0]           filled_qty_o,
  output logic [QTY_W-1:0]           rested_qty_o,
  output logic                       best_bid_valid_o,
  output logic [PRICE_W-1:0]         best_bid_price_o,
  output logic                       best_ask_valid_o,
  output logic [PRICE_W-1:0]         best_ask_price_o
);

  localparam int IDX_W     = $clog2(WINDOW_LEVELS);
  localparam int ROWS      = (WINDOW_LEVELS + MAP_WORD_W - 1) / MAP_WORD_W;
  localparam int ROW_W     = IDX_W - MAP_BIT_W;
  localparam int MAP_DEPTH = 2 * ROWS;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int SLOT_N    = 2 * WINDOW_LEVELS;
  localparam int SLOT_W    = $clog2(SLOT_N);
  localparam int Q_DEPTH   = SLOT_N * LEVEL_DEPTH;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
  localparam int ACT_W     = $clog2(WINDOW_LEVELS + 1);
  localparam int TRK_W     = $clog2(TRACKED_ORDERS);
  localparam int CLR_N     = (TRACKED_ORDERS > MAP_DEPTH) ? TRACKED_ORDERS : MAP_DEPTH;
  localparam int CLR_W     = $clog2(CLR_N);
  localparam int HALF      = WINDOW_LEVELS / 2;
  localparam int QE_W      = $bits(qent_t);
  localparam int TE_W      = $bits(trk_t);

  // sequencer states
  localparam int S_W = 5;
  localparam logic [S_W-1:0] S_CLR  = 5'd0;
  localparam logic [S_W-1:0] S_IDLE = 5'd1;
  localparam logic [S_W-1:0] S_MCHK = 5'd2;
  localparam logic [S_W-1:0] S_MCNT = 5'd3;
  localparam logic [S_W-1:0] S_HRD  = 5'd4;
  localparam logic [S_W-1:0] S_HEAD = 5'd5;
  localparam logic [S_W-1:0] S_RMRD = 5'd6;
  localparam logic [S_W-1:0] S_RMWR = 5'd7;
  localparam logic [S_W-1:0] S_LRD  = 5'd8;
  localparam logic [S_W-1:0] S_LWR  = 5'd9;
  localparam logic [S_W-1:0] S_SRD  = 5'd10;
  localparam logic [S_W-1:0] S_SCHK = 5'd11;
  localparam logic [S_W-1:0] S_MDON = 5'd12;
  localparam logic [S_W-1:0] S_R0   = 5'd13;
  localparam logic [S_W-1:0] S_R1   = 5'd14;
  localparam logic [S_W-1:0] S_R2   = 5'd15;
  localparam logic [S_W-1:0] S_C0   = 5'd16;
  localparam logic [S_W-1:0] S_C1   = 5'd17;
  localparam logic [S_W-1:0] S_C2   = 5'd18;
  localparam logic [S_W-1:0] S_CRD  = 5'd19;
  localparam logic [S_W-1:0] S_CCHK = 5'd20;
  localparam logic [S_W-1:0] S_OUT  = 5'd21;

  function automatic logic [SLOT_W-1:0] slot_of(logic s, logic [IDX_W-1:0] idx);
    slot_of = s ? SLOT_W'(WINDOW_LEVELS) + SLOT_W'(idx) : SLOT_W'(idx);
  endfunction

  function automatic logic [MAP_AW-1:0] row_of(logic s, logic [ROW_W-1:0] r);
    row_of = s ? MAP_AW'(ROWS) + MAP_AW'(r) : MAP_AW'(r);
  endfunction

  function automatic logic in_window(logic [PRICE_W-1:0] base, logic set,
                                     logic [PRICE_W-1:0] price);
    logic [PRICE_W-1:0] diff;
    diff      = price - base;
    in_window = set && (price >= base) && (diff < PRICE_W'(WINDOW_LEVELS));
  endfunction

  // control state
  logic [S_W-1:0]     state_q, state_d;
  logic [CLR_W-1:0]   clr_q, clr_d;
  logic               done_q, done_d;
  logic [PRICE_W-1:0] base_q [2];
  logic [PRICE_W-1:0] base_d [2];
  logic               base_set_q [2];
  logic               base_set_d [2];
  logic [IDX_W-1:0]   best_q [2];
  logic [IDX_W-1:0]   best_d [2];
  logic               best_ok_q [2];
  logic               best_ok_d [2];
  logic [ACT_W-1:0]   active_q [2];
  logic [ACT_W-1:0]   active_d [2];

  // item and work registers
  logic               op_q, op_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic               side_q, side_d;
  logic               market_q, market_d;
  logic [PRICE_W-1:0] price_q, price_d;
  logic [QTY_W-1:0]   qty_q, qty_d;
  logic [QTY_W-1:0]   filled_q, filled_d;
  logic [QTY_W-1:0]   rested_q, rested_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic               lside_q, lside_d;
  logic [IDX_W-1:0]   lidx_q, lidx_d;
  logic [CNT_W-1:0]   lcnt_q, lcnt_d;
  logic [CNT_W-1:0]   j_q, j_d;
  logic [ROW_W-1:0]   row_q, row_d;

  // result registers
  logic [STATUS_W-1:0] o_status_q, o_status_d;
  logic [QTY_W-1:0]    o_filled_q, o_filled_d;
  logic [QTY_W-1:0]    o_rested_q, o_rested_d;
  logic                o_bidv_q, o_bidv_d;
  logic [PRICE_W-1:0]  o_bidp_q, o_bidp_d;
  logic                o_askv_q, o_askv_d;
  logic [PRICE_W-1:0]  o_askp_q, o_askp_d;

  // memory ports
  logic                   map_we;
  logic [MAP_AW-1:0]      map_waddr, map_raddr;
  logic [MAP_WORD_W-1:0]  map_wdata, map_rdata;
  logic                   cnt_we;
  logic [SLOT_W-1:0]      cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]       cnt_wdata, cnt_rdata;
  logic                   q_we;
  logic [Q_AW-1:0]        q_waddr, q_raddr;
  logic [QE_W-1:0]        q_wdata, q_rdata;
  logic                   trk_we;
  logic [TRK_W-1:0]       trk_waddr, trk_raddr;
  logic [TE_W-1:0]        trk_wdata, trk_rdata;

  // scanner
  logic [MAP_WORD_W-1:0] scan_word;
  logic [MAP_BIT_W-1:0]  scan_from;
  scan_res_t             scan_res;

  logic                  fixed_window;
  logic [Q_AW-1:0]       qbase;
  logic [ROW_W-1:0]      lrow;
  logic [MAP_BIT_W-1:0]  lbit;
  logic [S_W-1:0]        st_done;

  assign qbase   = Q_AW'(slot_of(lside_q, lidx_q)) * Q_AW'(LEVEL_DEPTH);
  assign lrow    = lidx_q[IDX_W-1:MAP_BIT_W];
  assign lbit    = lidx_q[MAP_BIT_W-1:0];
  assign st_done = (op_q == OP_CANCEL) ? S_OUT : S_MCHK;

  lobm_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .fixed_window_o (fixed_window)
  );

  lobm_scan u_scan (
    .word_i (scan_word),
    .from_i (scan_from),
    .dir_i  (lside_q),
    .res_o  (scan_res)
  );

  lobm_ram #(.Width(MAP_WORD_W), .Depth(MAP_DEPTH)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  lobm_ram #(.Width(CNT_W), .Depth(SLOT_N)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  lobm_ram #(.Width(QE_W), .Depth(Q_DEPTH)) u_q_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  lobm_ram #(.Width(TE_W), .Depth(TRACKED_ORDERS)) u_trk_ram (
    .clk_i   (clk_i),
    .we_i    (trk_we),
    .waddr_i (trk_waddr),
    .wdata_i (trk_wdata),
    .raddr_i (trk_raddr),
    .rdata_o (trk_rdata)
  );

  // sequencer
  always_comb begin
    logic               o;
    logic               s;
    logic [PRICE_W-1:0] bp;
    logic [PRICE_W-1:0] newbase;
    logic [IDX_W-1:0]   idx;
    logic [MAP_WORD_W-1:0] w;
    logic [CNT_W-1:0]   ncnt;
    logic [CNT_W-1:0]   cur;
    logic [QTY_W-1:0]   t;
    logic [QTY_W-1:0]   nq;
    logic               mapbit;
    qent_t              ent;
    qent_t              went;
    trk_t               trk;
    trk_t               wtrk;

    o       = ~side_q;
    s       = side_q;
    bp      = '0;
    newbase = (price_q > PRICE_W'(HALF)) ? price_q - PRICE_W'(HALF) : '0;
    idx     = '0;
    w       = '0;
    ncnt    = '0;
    cur     = '0;
    t       = '0;
    nq      = '0;
    mapbit  = 1'b0;
    ent     = qent_t'(q_rdata);
    went    = '0;
    trk     = trk_t'(trk_rdata);
    wtrk    = '0;

    state_d    = state_q;
    clr_d      = clr_q;
    done_d     = 1'b0;
    base_d     = base_q;
    base_set_d = base_set_q;
    best_d     = best_q;
    best_ok_d  = best_ok_q;
    active_d   = active_q;
    op_d       = op_q;
    id_d       = id_q;
    side_d     = side_q;
    market_d   = market_q;
    price_d    = price_q;
    qty_d      = qty_q;
    filled_d   = filled_q;
    rested_d   = rested_q;
    status_d   = status_q;
    lside_d    = lside_q;
    lidx_d     = lidx_q;
    lcnt_d     = lcnt_q;
    j_d        = j_q;
    row_d      = row_q;
    o_status_d = o_status_q;
    o_filled_d = o_filled_q;
    o_rested_d = o_rested_q;
    o_bidv_d   = o_bidv_q;
    o_bidp_d   = o_bidp_q;
    o_askv_d   = o_askv_q;
    o_askp_d   = o_askp_q;

    map_we    = 1'b0;
    map_waddr = '0;
    map_wdata = '0;
    map_raddr = '0;
    cnt_we    = 1'b0;
    cnt_waddr = '0;
    cnt_wdata = '0;
    cnt_raddr = '0;
    q_we      = 1'b0;
    q_waddr   = '0;
    q_wdata   = '0;
    q_raddr   = '0;
    trk_we    = 1'b0;
    trk_waddr = '0;
    trk_wdata = '0;
    trk_raddr = '0;
    scan_word = map_rdata;
    scan_from = (lside_q == SIDE_BUY) ? BIT_TOP : BIT_BOTTOM;

    case (state_q)
      // wipe tracker and bitmap after reset
      S_CLR: begin
        if (32'(clr_q) < 32'(MAP_DEPTH)) begin
          map_we    = 1'b1;
          map_waddr = clr_q[MAP_AW-1:0];
        end
        if (32'(clr_q) < 32'(TRACKED_ORDERS)) begin
          trk_we    = 1'b1;
          trk_waddr = clr_q[TRK_W-1:0];
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_W'(CLR_N - 1)) begin
          state_d = S_IDLE;
        end
      end

      // take the next item
      S_IDLE: begin
        if (start) begin
          op_d     = op_i;
          id_d     = order_id_i;
          side_d   = side_i;
          market_d = (order_kind_i == KIND_MARKET);
          price_d  = price_i;
          qty_d    = quantity_i;
          filled_d = '0;
          rested_d = '0;
          state_d  = (op_i == OP_CANCEL) ? S_C0 : S_MCHK;
        end
      end

      // check whether the opposite best level crosses
      S_MCHK: begin
        bp = base_q[o] + PRICE_W'(best_q[o]);
        if (qty_q == '0 || !best_ok_q[o]) begin
          state_d = S_MDON;
        end else if (!market_q && ((s == SIDE_BUY && bp > price_q) ||
                                   (s == SIDE_SELL && bp < price_q))) begin
          state_d = S_MDON;
        end else begin
          lside_d   = o;
          lidx_d    = best_q[o];
          cnt_raddr = slot_of(o, best_q[o]);
          state_d   = S_MCNT;
        end
      end

      S_MCNT: begin
        lcnt_d = cnt_rdata;
        if (cnt_rdata == '0) begin
          state_d = S_LRD;
        end else begin
          q_raddr = qbase;
          state_d = S_HEAD;
        end
      end

      S_HRD: begin
        q_raddr = qbase;
        state_d = S_HEAD;
      end

      // trade against the oldest order of the level
      S_HEAD: begin
        t        = (ent.qty < qty_q) ? ent.qty : qty_q;
        qty_d    = qty_q - t;
        filled_d = filled_q + t;
        nq       = ent.qty - t;
        if (nq != '0) begin
          went.id  = ent.id;
          went.qty = nq;
          q_we     = 1'b1;
          q_waddr  = qbase;
          q_wdata  = went;
          state_d  = S_MCHK;
        end else begin
          if (ent.id < ID_W'(TRACKED_ORDERS)) begin
            trk_we    = 1'b1;
            trk_waddr = ent.id[TRK_W-1:0];
          end
          j_d     = '0;
          state_d = S_RMRD;
        end
      end

      // shift the queue up over the removed entry
      S_RMRD: begin
        if (32'(j_q) + 32'd1 < 32'(lcnt_q)) begin
          q_raddr = qbase + Q_AW'(j_q) + Q_AW'(1);
          state_d = S_RMWR;
        end else begin
          ncnt      = lcnt_q - 1'b1;
          cnt_we    = 1'b1;
          cnt_waddr = slot_of(lside_q, lidx_q);
          cnt_wdata = ncnt;
          lcnt_d    = ncnt;
          if (op_q == OP_CANCEL) begin
            status_d = STAT_CANCELLED;
            state_d  = (ncnt == '0) ? S_LRD : S_OUT;
          end else if (ncnt == '0) begin
            state_d = S_LRD;
          end else begin
            state_d = (qty_q != '0) ? S_HRD : S_MCHK;
          end
        end
      end

      S_RMWR: begin
        q_we    = 1'b1;
        q_waddr = qbase + Q_AW'(j_q);
        q_wdata = q_rdata;
        j_d     = j_q + 1'b1;
        state_d = S_RMRD;
      end

      // drop an emptied level from the bitmap
      S_LRD: begin
        map_raddr = row_of(lside_q, lrow);
        state_d   = S_LWR;
      end

      S_LWR: begin
        w         = map_rdata & ~(MAP_WORD_W'(1) << lbit);
        map_we    = 1'b1;
        map_waddr = row_of(lside_q, lrow);
        map_wdata = w;
        if (active_q[lside_q] != '0) begin
          active_d[lside_q] = active_q[lside_q] - 1'b1;
        end
        scan_word = w;
        scan_from = lbit;
        state_d   = st_done;
        if (best_ok_q[lside_q] && best_q[lside_q] == lidx_q) begin
          if (scan_res.found) begin
            best_d[lside_q] = {lrow, scan_res.pos};
          end else begin
            best_ok_d[lside_q] = 1'b0;
            if (lside_q == SIDE_BUY) begin
              if (lrow != '0) begin
                row_d   = lrow - 1'b1;
                state_d = S_SRD;
              end
            end else if (lrow != ROW_W'(ROWS - 1)) begin
              row_d   = lrow + 1'b1;
              state_d = S_SRD;
            end
          end
        end
      end

      // walk bitmap words for the next best level
      S_SRD: begin
        map_raddr = row_of(lside_q, row_q);
        state_d   = S_SCHK;
      end

      S_SCHK: begin
        state_d = st_done;
        if (scan_res.found) begin
          best_d[lside_q]    = {row_q, scan_res.pos};
          best_ok_d[lside_q] = 1'b1;
        end else if (lside_q == SIDE_BUY) begin
          if (row_q != '0) begin
            row_d   = row_q - 1'b1;
            state_d = S_SRD;
          end
        end else if (row_q != ROW_W'(ROWS - 1)) begin
          row_d   = row_q + 1'b1;
          state_d = S_SRD;
        end
      end

      // settle what is left after matching
      S_MDON: begin
        if (qty_q == '0) begin
          status_d = STAT_FILLED;
          state_d  = S_OUT;
        end else if (market_q) begin
          status_d = STAT_DROPPED;
          state_d  = S_OUT;
        end else begin
          state_d = S_R0;
        end
      end

      // re-base the window when allowed
      S_R0: begin
        if (fixed_window) begin
          if (!base_set_q[s] || active_q[s] == '0) begin
            base_d[s]     = '0;
            base_set_d[s] = 1'b1;
            best_ok_d[s]  = 1'b0;
          end
        end else if (!base_set_q[s]) begin
          base_d[s]     = newbase;
          base_set_d[s] = 1'b1;
          best_ok_d[s]  = 1'b0;
        end else if (!in_window(base_q[s], 1'b1, price_q) && active_q[s] == '0) begin
          base_d[s]    = newbase;
          best_ok_d[s] = 1'b0;
        end
        state_d = S_R1;
      end

      S_R1: begin
        if (!in_window(base_q[s], base_set_q[s], price_q)) begin
          status_d = STAT_OUTSIDE;
          state_d  = S_OUT;
        end else begin
          idx       = IDX_W'(price_q - base_q[s]);
          lside_d   = s;
          lidx_d    = idx;
          map_raddr = row_of(s, idx[IDX_W-1:MAP_BIT_W]);
          cnt_raddr = slot_of(s, idx);
          state_d   = S_R2;
        end
      end

      // append the remainder to its level
      S_R2: begin
        mapbit = map_rdata[lbit];
        cur    = mapbit ? cnt_rdata : '0;
        if (mapbit && 32'(cnt_rdata) >= 32'(LEVEL_DEPTH)) begin
          status_d = STAT_FULL;
        end else begin
          if (!mapbit) begin
            map_we    = 1'b1;
            map_waddr = row_of(lside_q, lrow);
            map_wdata = map_rdata | (MAP_WORD_W'(1) << lbit);
            active_d[lside_q] = active_q[lside_q] + 1'b1;
            if (!best_ok_q[lside_q] ||
                (lside_q == SIDE_BUY && lidx_q > best_q[lside_q]) ||
                (lside_q == SIDE_SELL && lidx_q < best_q[lside_q])) begin
              best_d[lside_q]    = lidx_q;
              best_ok_d[lside_q] = 1'b1;
            end
          end
          went.id   = id_q;
          went.qty  = qty_q;
          q_we      = 1'b1;
          q_waddr   = qbase + Q_AW'(cur);
          q_wdata   = went;
          cnt_we    = 1'b1;
          cnt_waddr = slot_of(lside_q, lidx_q);
          cnt_wdata = cur + 1'b1;
          if (id_q < ID_W'(TRACKED_ORDERS)) begin
            wtrk.active = 1'b1;
            wtrk.side   = lside_q;
            wtrk.price  = price_q;
            trk_we      = 1'b1;
            trk_waddr   = id_q[TRK_W-1:0];
            trk_wdata   = wtrk;
          end
          status_d = STAT_RESTED;
          rested_d = qty_q;
        end
        state_d = S_OUT;
      end

      // cancel: look up the tracker
      S_C0: begin
        if (id_q >= ID_W'(TRACKED_ORDERS)) begin
          status_d = STAT_NOTFOUND;
          state_d  = S_OUT;
        end else begin
          trk_raddr = id_q[TRK_W-1:0];
          state_d   = S_C1;
        end
      end

      S_C1: begin
        if (!trk.active || !in_window(base_q[trk.side], base_set_q[trk.side], trk.price)) begin
          status_d = STAT_NOTFOUND;
          state_d  = S_OUT;
        end else begin
          idx       = IDX_W'(trk.price - base_q[trk.side]);
          lside_d   = trk.side;
          lidx_d    = idx;
          map_raddr = row_of(trk.side, idx[IDX_W-1:MAP_BIT_W]);
          cnt_raddr = slot_of(trk.side, idx);
          state_d   = S_C2;
        end
      end

      S_C2: begin
        if (!map_rdata[lbit]) begin
          status_d = STAT_NOTFOUND;
          state_d  = S_OUT;
        end else begin
          lcnt_d  = cnt_rdata;
          j_d     = '0;
          state_d = S_CRD;
        end
      end

      // search the level for the id
      S_CRD: begin
        if (j_q >= lcnt_q) begin
          status_d = STAT_NOTFOUND;
          state_d  = S_OUT;
        end else begin
          q_raddr = qbase + Q_AW'(j_q);
          state_d = S_CCHK;
        end
      end

      S_CCHK: begin
        if (ent.id == id_q) begin
          trk_we    = 1'b1;
          trk_waddr = id_q[TRK_W-1:0];
          state_d   = S_RMRD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_CRD;
        end
      end

      // present the result for one cycle
      S_OUT: begin
        o_status_d = status_q;
        o_filled_d = filled_q;
        o_rested_d = rested_q;
        o_bidv_d   = best_ok_q[0];
        o_bidp_d   = best_ok_q[0] ? base_q[0] + PRICE_W'(best_q[0]) : '0;
        o_askv_d   = best_ok_q[1];
        o_askp_d   = best_ok_q[1] ? base_q[1] + PRICE_W'(best_q[1]) : '0;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        base_q[k]     <= '0;
        base_set_q[k] <= 1'b0;
        best_q[k]     <= '0;
        best_ok_q[k]  <= 1'b0;
        active_q[k]   <= '0;
      end
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      done_q     <= done_d;
      base_q     <= base_d;
      base_set_q <= base_set_d;
      best_q     <= best_d;
      best_ok_q  <= best_ok_d;
      active_q   <= active_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    side_q     <= side_d;
    market_q   <= market_d;
    price_q    <= price_d;
    qty_q      <= qty_d;
    filled_q   <= filled_d;
    rested_q   <= rested_d;
    status_q   <= status_d;
    lside_q    <= lside_d;
    lidx_q     <= lidx_d;
    lcnt_q     <= lcnt_d;
    j_q        <= j_d;
    row_q      <= row_d;
    o_status_q <= o_status_d;
    o_filled_q <= o_filled_d;
    o_rested_q <= o_rested_d;
    o_bidv_q   <= o_bidv_d;
    o_bidp_q   <= o_bidp_d;
    o_askv_q   <= o_askv_d;
    o_askp_q   <= o_askp_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = o_status_q;
  assign filled_qty_o     = o_filled_q;
  assign rested_qty_o     = o_rested_q;
  assign best_bid_valid_o = o_bidv_q;
  assign best_bid_price_o = o_bidp_q;
  assign best_ask_valid_o = o_askv_q;
  assign best_ask_price_o = o_askp_q;

  // checks
  a_clr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> busy)
    else $error("clearing pass without busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

  a_bid_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_ok_q[0] |-> (active_q[0] != '0))
    else $error("best bid valid with no active level");

  a_ask_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_ok_q[1] |-> (active_q[1] != '0))
    else $error("best ask valid with no active level");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item accepted without going busy");

  a_rested_qty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && o_status_q == STAT_RESTED) |-> (o_rested_q != '0))
    else $error("rested status with zero rested quantity");

endmodule

`default_nettype wire

### design/lobm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/lobm_scan.sv
// ----------------------------------------------------------------------------
// Level bitmap scanner
// Finds the highest set bit at or below a position, or the lowest at or above.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_scan
  import lobm_pkg::*;
(
  input  wire logic [MAP_WORD_W-1:0] word_i,
  input  wire logic [MAP_BIT_W-1:0]  from_i,
  input  wire logic                  dir_i,   // SIDE_BUY: highest, SIDE_SELL: lowest
  output scan_res_t                  res_o
);

  logic [MAP_WORD_W-1:0] masked;

  // keep only bits on the search side of the start position
  always_comb begin
    for (int i = 0; i < MAP_WORD_W; i++) begin
      if (dir_i == SIDE_BUY) begin
        masked[i] = word_i[i] && (MAP_BIT_W'(i) <= from_i);
      end else begin
        masked[i] = word_i[i] && (MAP_BIT_W'(i) >= from_i);
      end
    end
  end

  // priority encode toward the search direction
  always_comb begin
    res_o = '0;
    if (dir_i == SIDE_BUY) begin
      for (int i = 0; i < MAP_WORD_W; i++) begin
        if (masked[i]) begin
          res_o.found = 1'b1;
          res_o.pos   = MAP_BIT_W'(i);
        end
      end
    end else begin
      for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
        if (masked[i]) begin
          res_o.found = 1'b1;
          res_o.pos   = MAP_BIT_W'(i);
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/lobm_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style slave holding the fixed window mode bit.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_cfg
  import lobm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic                       fixed_window_o
);

  logic fixed_q, fixed_d;
  logic hit;

  // register index is the word address
  assign hit = (paddr[CFG_ADDR_W-1:2] == ADDR_FIXED_WINDOW[CFG_ADDR_W-1:2]);

  always_comb begin
    fixed_d = fixed_q;
    if (psel && penable && pwrite && hit) begin
      fixed_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_q <= 1'b0;
    end else begin
      fixed_q <= fixed_d;
    end
  end

  assign prdata         = hit ? CFG_DATA_W'(fixed_q) : '0;
  assign pready         = 1'b1;
  assign fixed_window_o = fixed_q;

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// Limit order book matcher testbench
// Drives new orders and cancels through the command port, predicts every
// result with an in-bench copy of the book, and checks each result field by
// field. Runs directed corner orders, then random bursts under both window
// modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lobm_pkg::*;

  localparam int WL = 1024;
  localparam int TO = 4096;
  localparam int LD = 16;

  typedef struct {
    logic              op;
    logic [ID_W-1:0]   id;
    logic              side;
    logic              kind;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]  qty;
  } order_item_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [QTY_W-1:0]    filled;
    logic [QTY_W-1:0]    rested;
    logic                bid_ok;
    logic [PRICE_W-1:0]  bid_px;
    logic                ask_ok;
    logic [PRICE_W-1:0]  ask_px;
  } book_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic op_i = 1'b0, side_i = 1'b0, order_kind_i = 1'b0;
  logic [ID_W-1:0] order_id_i = '0;
  logic [PRICE_W-1:0] price_i = '0;
  logic [QTY_W-1:0] quantity_i = '0;
  logic done_o;
  logic [STATUS_W-1:0] status_o;
  logic [QTY_W-1:0] filled_qty_o, rested_qty_o;
  logic best_bid_valid_o, best_ask_valid_o;
  logic [PRICE_W-1:0] best_bid_price_o, best_ask_price_o;

  limit_order_book_matcher_core u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .op_i, .order_id_i, .side_i, .order_kind_i, .price_i,
    .quantity_i, .done_o, .status_o, .filled_qty_o, .rested_qty_o,
    .best_bid_valid_o, .best_bid_price_o, .best_ask_valid_o, .best_ask_price_o
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Book copy used for prediction
  // ---------------------------------------------------------------------------
  bit          fixed_mode;
  bit [31:0]   win_base [2];
  bit          base_ok [2];
  bit          lvl_on [2][WL];
  int unsigned top_idx [2];
  bit          top_ok [2];
  int unsigned live_lvls [2];
  int unsigned lvl_cnt [2*WL];
  bit [31:0]   q_id [2*WL*LD];
  bit [31:0]   q_qty [2*WL*LD];
  bit          trk_on [TO];
  bit          trk_side [TO];
  bit [31:0]   trk_px [TO];

  order_item_t  pending_q[$];
  book_result_t expected_q[$];
  int err_cnt = 0;

  function automatic bit px_in_window(int s, bit [31:0] px);
    bit [31:0] off;
    off = px - win_base[s];
    return base_ok[s] && px >= win_base[s] && off < WL;
  endfunction

  // Drop one level and search for the next best one
  function automatic void drop_level(int s, int unsigned idx);
    int i;
    if (!lvl_on[s][idx]) return;
    lvl_on[s][idx] = 0;
    lvl_cnt[s*WL + idx] = 0;
    if (live_lvls[s] > 0) live_lvls[s]--;
    if (!top_ok[s] || top_idx[s] != idx) return;
    top_ok[s] = 0;
    if (s == 0) begin
      for (i = idx; i >= 0; i--)
        if (lvl_on[s][i]) begin top_idx[s] = i; top_ok[s] = 1; break; end
    end else begin
      for (i = idx; i < WL; i++)
        if (lvl_on[s][i]) begin top_idx[s] = i; top_ok[s] = 1; break; end
    end
  endfunction

  function automatic void pull_entry(int unsigned slot, int unsigned j);
    int unsigned n;
    n = lvl_cnt[slot];
    for (int unsigned k = j; k + 1 < n; k++) begin
      q_id[slot*LD + k]  = q_id[slot*LD + k + 1];
      q_qty[slot*LD + k] = q_qty[slot*LD + k + 1];
    end
    lvl_cnt[slot] = n - 1;
  endfunction

  // Trade against the opposite side, return the remainder
  function automatic bit [31:0] trade_book(int s, bit mkt, bit [31:0] px, bit [31:0] qty);
    int o;
    int unsigned idx, slot;
    bit [31:0] lvl_px, t;
    o = s ^ 1;
    while (qty > 0 && top_ok[o]) begin
      idx = top_idx[o];
      lvl_px = win_base[o] + idx;
      slot = o*WL + idx;
      if (!mkt && ((s == 0 && lvl_px > px) || (s == 1 && lvl_px < px))) break;
      while (lvl_cnt[slot] > 0 && qty > 0) begin
        t = (q_qty[slot*LD] < qty) ? q_qty[slot*LD] : qty;
        qty -= t;
        q_qty[slot*LD] -= t;
        if (q_qty[slot*LD] != 0) break;
        if (q_id[slot*LD] < TO) trk_on[q_id[slot*LD]] = 0;
        pull_entry(slot, 0);
      end
      if (lvl_cnt[slot] == 0) drop_level(o, idx);
    end
    return qty;
  endfunction

  // Rest a limit remainder, return its status
  function automatic logic [STATUS_W-1:0] rest_order(int s, bit [31:0] id, bit [31:0] px,
                                                     bit [31:0] qty);
    bit [31:0] nb;
    int unsigned idx, slot;
    nb = (px > WL/2) ? px - WL/2 : 0;
    if (fixed_mode) begin
      if (!base_ok[s] || live_lvls[s] == 0) begin
        win_base[s] = 0; base_ok[s] = 1; top_ok[s] = 0;
      end
    end else if (!base_ok[s]) begin
      win_base[s] = nb; base_ok[s] = 1; top_ok[s] = 0;
    end else if (!px_in_window(s, px) && live_lvls[s] == 0) begin
      win_base[s] = nb; top_ok[s] = 0;
    end
    if (!px_in_window(s, px)) return STAT_OUTSIDE;
    idx = px - win_base[s];
    slot = s*WL + idx;
    if (lvl_on[s][idx] && lvl_cnt[slot] >= LD) return STAT_FULL;
    if (!lvl_on[s][idx]) begin
      lvl_on[s][idx] = 1;
      lvl_cnt[slot] = 0;
      live_lvls[s]++;
      if (!top_ok[s] || (s == 0 && idx > top_idx[s]) || (s == 1 && idx < top_idx[s])) begin
        top_idx[s] = idx; top_ok[s] = 1;
      end
    end
    q_id[slot*LD + lvl_cnt[slot]]  = id;
    q_qty[slot*LD + lvl_cnt[slot]] = qty;
    lvl_cnt[slot]++;
    if (id < TO) begin
      trk_on[id] = 1; trk_side[id] = s; trk_px[id] = px;
    end
    return STAT_RESTED;
  endfunction

  function automatic bit withdraw_order(bit [31:0] id);
    int s;
    int unsigned idx, slot;
    if (id >= TO || !trk_on[id]) return 0;
    s = trk_side[id];
    if (!px_in_window(s, trk_px[id])) return 0;
    idx = trk_px[id] - win_base[s];
    if (!lvl_on[s][idx]) return 0;
    slot = s*WL + idx;
    for (int unsigned j = 0; j < lvl_cnt[slot]; j++) begin
      if (q_id[slot*LD + j] != id) continue;
      pull_entry(slot, j);
      trk_on[id] = 0;
      if (lvl_cnt[slot] == 0) drop_level(s, idx);
      return 1;
    end
    return 0;
  endfunction

  function automatic book_result_t book_step(order_item_t it);
    book_result_t r;
    bit [31:0] rem;
    r.filled = 0;
    r.rested = 0;
    if (it.op == OP_CANCEL) begin
      r.status = withdraw_order(it.id) ? STAT_CANCELLED : STAT_NOTFOUND;
    end else begin
      rem = trade_book(it.side, it.kind == KIND_MARKET, it.price, it.qty);
      r.filled = it.qty - rem;
      if (rem == 0) r.status = STAT_FILLED;
      else if (it.kind == KIND_MARKET) r.status = STAT_DROPPED;
      else begin
        r.status = rest_order(it.side, it.id, it.price, rem);
        if (r.status == STAT_RESTED) r.rested = rem;
      end
    end
    r.bid_ok = top_ok[0];
    r.bid_px = top_ok[0] ? win_base[0] + top_idx[0] : 0;
    r.ask_ok = top_ok[1];
    r.ask_px = top_ok[1] ? win_base[1] + top_idx[1] : 0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of items with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    order_item_t it;
    book_result_t r;
    bit taken;
    if (rst_ni) begin
      taken = start && !busy;
      if (taken) begin
        it.op = op_i; it.id = order_id_i; it.side = side_i; it.kind = order_kind_i;
        it.price = price_i; it.qty = quantity_i;
        r = book_step(it);
        expected_q.push_back(r);
      end
      if (start && !taken) begin
        // hold the item until accepted
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        it = pending_q[0];
        pending_q.delete(0);
        op_i <= it.op; order_id_i <= it.id; side_i <= it.side;
        order_kind_i <= it.kind; price_i <= it.price; quantity_i <= it.qty;
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result with the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    book_result_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding");
        err_cnt++;
      end else begin
        e = expected_q[0];
        expected_q.delete(0);
        check_field("status", e.status, status_o);
        check_field("filled_qty", e.filled, filled_qty_o);
        check_field("rested_qty", e.rested, rested_qty_o);
        check_field("best_bid_valid", e.bid_ok, best_bid_valid_o);
        check_field("best_bid_price", e.bid_px, best_bid_price_o);
        check_field("best_ask_valid", e.ask_ok, best_ask_valid_o);
        check_field("best_ask_price", e.ask_px, best_ask_price_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic order_item_t mk(logic op, logic [31:0] id, logic side, logic kind,
                                     logic [31:0] px, logic [31:0] qty);
    order_item_t it;
    it.op = op; it.id = id; it.side = side; it.kind = kind; it.price = px; it.qty = qty;
    return it;
  endfunction

  // Random order near a center price, with occasional full-range fields
  function automatic order_item_t rand_order(bit [31:0] center);
    order_item_t it;
    int sel;
    it.op = ($urandom_range(0, 99) < 15) ? OP_CANCEL : OP_NEW;
    it.id = ($urandom_range(0, 99) < 5) ? $urandom() : $urandom_range(0, 400);
    if ($urandom_range(0, 199) == 0) it.id = TO - 1 + $urandom_range(0, 1);
    it.side = $urandom_range(0, 1);
    it.kind = ($urandom_range(0, 99) < 10) ? KIND_MARKET : KIND_LIMIT;
    sel = $urandom_range(0, 99);
    if (sel < 4) it.price = $urandom();
    else if (it.side == SIDE_BUY) it.price = center - 12 + $urandom_range(0, 16);
    else it.price = center - 4 + $urandom_range(0, 16);
    sel = $urandom_range(0, 99);
    if (sel < 2) it.qty = 0;
    else if (sel < 4) it.qty = $urandom();
    else it.qty = $urandom_range(1, 60);
    return it;
  endfunction

  task automatic cfg_write(logic [CFG_DATA_W-1:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_FIXED_WINDOW; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    fixed_mode = v[0];
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || start || expected_q.size() > 0 || busy)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic run_random(int n, bit [31:0] center);
    for (int i = 0; i < n; i++) pending_q.push_back(rand_order(center));
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();
    cfg_write(0);

    // directed corners in re-based window mode
    pending_q.push_back(mk(OP_NEW, 9, SIDE_BUY, KIND_LIMIT, 1000, 0));
    pending_q.push_back(mk(OP_NEW, 9, SIDE_SELL, KIND_MARKET, 1000, 5));
    for (int i = 1; i <= LD + 1; i++)
      pending_q.push_back(mk(OP_NEW, i, SIDE_BUY, KIND_LIMIT, 1000, 10));
    pending_q.push_back(mk(OP_NEW, 20, SIDE_BUY, KIND_LIMIT, 32'hFFFF_FFFF, 3));
    pending_q.push_back(mk(OP_NEW, 32'hFFFF_FFFF, SIDE_SELL, KIND_LIMIT, 1001, 7));
    pending_q.push_back(mk(OP_CANCEL, 32'hFFFF_FFFF, SIDE_SELL, KIND_LIMIT, 0, 0));
    pending_q.push_back(mk(OP_CANCEL, 3, SIDE_BUY, KIND_LIMIT, 0, 0));
    pending_q.push_back(mk(OP_NEW, 2, SIDE_BUY, KIND_LIMIT, 999, 4));
    pending_q.push_back(mk(OP_CANCEL, 4095, SIDE_BUY, KIND_LIMIT, 0, 0));
    pending_q.push_back(mk(OP_NEW, 21, SIDE_SELL, KIND_MARKET, 0, 32'hFFFF_FFFF));
    pending_q.push_back(mk(OP_CANCEL, 2, SIDE_BUY, KIND_LIMIT, 0, 0));
    wait_idle();
    run_random(600, $urandom_range(2000, 1000000));

    // anchored window, including a price just past the window
    cfg_write(1);
    pending_q.push_back(mk(OP_NEW, 30, SIDE_BUY, KIND_LIMIT, WL, 5));
    pending_q.push_back(mk(OP_NEW, 31, SIDE_BUY, KIND_LIMIT, WL - 1, 5));
    pending_q.push_back(mk(OP_NEW, 32, SIDE_SELL, KIND_LIMIT, 0, 5));
    wait_idle();
    run_random(500, 500);

    // back to re-based mode near the bottom of the price range
    cfg_write(0);
    run_random(400, $urandom_range(0, 600));

    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
